FILE: rtl/core/html_to_text_stripper_assert.svh
// Assertion macros for the rich-text stripper core.
// Depends on nothing; expects clk and arst_n in the including scope.
`ifndef HTML_TO_TEXT_STRIPPER_ASSERT_SVH
`define HTML_TO_TEXT_STRIPPER_ASSERT_SVH

// cond must hold in every cycle out of reset
`define H2T_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// ante in a cycle implies cons in the same cycle
`define H2T_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante in a cycle implies cons in the next cycle
`define H2T_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/h2t_pkg.sv
// Shared types and constants of the rich-text stripper.
// No dependencies.
package h2t_pkg;

	localparam int CHAR_BITS = 8;
	localparam int ENT_W     = 4 * CHAR_BITS;

	typedef struct packed {
		logic [7:0] in_char;
		logic       last;
	} src_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_valid;
		logic       end_of_text;
	} res_t;

	// parser mode
	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_TAG   = 2'd1;
	localparam logic [1:0] MODE_ENT   = 2'd2;

	// tag name match progress
	localparam logic [2:0] TM_EMPTY   = 3'd0;
	localparam logic [2:0] TM_B       = 3'd1;
	localparam logic [2:0] TM_BR      = 3'd2;
	localparam logic [2:0] TM_P       = 3'd3;
	localparam logic [2:0] TM_SLASH   = 3'd4;
	localparam logic [2:0] TM_SLASH_P = 3'd5;
	localparam logic [2:0] TM_NONE    = 3'd7;

	// characters
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NEL   = 8'h85;
	localparam logic [7:0] CH_NBSP  = 8'hA0;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// entity names packed as they sit in the entity buffer
	localparam logic [ENT_W-1:0] ENT_AMP = ENT_W'({CHAR_BITS'(8'h61), CHAR_BITS'(8'h6D),
		CHAR_BITS'(8'h70)});
	localparam logic [ENT_W-1:0] ENT_LT = ENT_W'({CHAR_BITS'(8'h6C), CHAR_BITS'(8'h74)});
	localparam logic [ENT_W-1:0] ENT_GT = ENT_W'({CHAR_BITS'(8'h67), CHAR_BITS'(8'h74)});
	localparam logic [ENT_W-1:0] ENT_QUOT = ENT_W'({CHAR_BITS'(8'h71), CHAR_BITS'(8'h75),
		CHAR_BITS'(8'h6F), CHAR_BITS'(8'h74)});
	localparam logic [ENT_W-1:0] ENT_APOS = ENT_W'({CHAR_BITS'(8'h61), CHAR_BITS'(8'h70),
		CHAR_BITS'(8'h6F), CHAR_BITS'(8'h73)});

endpackage

FILE: rtl/core/html_to_text_stripper.sv
// Rich-text to plain-text stripper core: input register, parser logic, result register.
// Depends on h2t_pkg and html_to_text_stripper_assert.svh.

// Takes one Latin-1 character per transaction on the src channel and returns exactly one
// result transaction per character on the res channel, carrying at most one plain-text
// character (out_valid tells whether out_char holds one) and end_of_text copied from last.
// Tags are swallowed (br gives a newline, p and /p give one once text has been emitted),
// the entities amp, lt, gt, quot and apos are decoded, whitespace is collapsed and LF is
// dropped. A character is accepted every cycle unless the result register stalls; res
// valid rises once it has passed the input register into the result register. Throughput
// is set by the parser state loop, from the parser state registers through the parser
// logic. After a character with last set all parser state returns to its reset values.
module html_to_text_stripper
	import h2t_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic src_valid,
	output logic src_ready,
	input  src_t src_data,
	output logic res_valid,
	input  logic res_ready,
	output res_t res_data
);

	// pipeline registers
	logic valid_s1;
	src_t data_s1;
	logic valid_s2;
	res_t data_s2;

	// parser state
	logic [1:0]       mode_q;
	logic [2:0]       tag_match_q;
	logic             tag_done_q;
	logic [ENT_W-1:0] ent_buf_q;
	logic [2:0]       ent_len_q;
	logic             ent_long_q;
	logic             emitted_q;
	logic             last_space_q;

	logic advance_s2;
	logic advance_s1;

	// next state and result
	logic [1:0]       mode_d;
	logic [2:0]       tag_match_d;
	logic             tag_done_d;
	logic [ENT_W-1:0] ent_buf_d;
	logic [2:0]       ent_len_d;
	logic             ent_long_d;
	logic             emitted_d;
	logic             last_space_d;
	logic             oc_valid;
	logic [7:0]       oc;
	logic             clear_markup;
	logic [7:0]       c;
	logic             is_ws;
	logic             text_idle;

	assign advance_s2 = !valid_s2 || res_ready;
	assign advance_s1 = valid_s1 && advance_s2;
	assign src_ready  = !valid_s1 || advance_s2;

	assign res_valid = valid_s2;
	assign res_data  = data_s2;

	assign c     = data_s1.in_char;
	assign is_ws = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE || c == CH_NEL;

	function automatic logic [2:0] tag_advance(input logic [2:0] m, input logic [7:0] ch);
		logic [2:0] r;
		r = TM_NONE;
		unique case (m)
			TM_EMPTY: begin
				if (ch == CH_B)
					r = TM_B;
				else if (ch == CH_P)
					r = TM_P;
				else if (ch == CH_SLASH)
					r = TM_SLASH;
			end
			TM_B:     if (ch == CH_R) r = TM_BR;
			TM_SLASH: if (ch == CH_P) r = TM_SLASH_P;
			default:  r = TM_NONE;
		endcase
		return r;
	endfunction

	always_comb begin
		mode_d       = mode_q;
		tag_match_d  = tag_match_q;
		tag_done_d   = tag_done_q;
		ent_buf_d    = ent_buf_q;
		ent_len_d    = ent_len_q;
		ent_long_d   = ent_long_q;
		oc_valid     = 1'b0;
		oc           = 8'h00;
		clear_markup = 1'b0;

		unique case (mode_q)
			MODE_TAG: begin
				if (c == CH_GT) begin
					// tag closes: newline for br, for p and /p only after some text
					if (tag_match_q == TM_BR) begin
						oc_valid = 1'b1;
						oc       = CH_LF;
					end else if ((tag_match_q == TM_P || tag_match_q == TM_SLASH_P)
							&& emitted_q) begin
						oc_valid = 1'b1;
						oc       = CH_LF;
					end
					clear_markup = 1'b1;
				end else if (!tag_done_q) begin
					if (c == CH_SPACE)
						tag_done_d = 1'b1;
					else
						tag_match_d = tag_advance(tag_match_q, c);
				end
			end
			MODE_ENT: begin
				if (c == CH_SEMI) begin
					if (!ent_long_q) begin
						if (ent_len_q == 3'd3 && ent_buf_q == ENT_AMP) begin
							oc_valid = 1'b1;
							oc       = CH_AMP;
						end else if (ent_len_q == 3'd2 && ent_buf_q == ENT_LT) begin
							oc_valid = 1'b1;
							oc       = CH_LT;
						end else if (ent_len_q == 3'd2 && ent_buf_q == ENT_GT) begin
							oc_valid = 1'b1;
							oc       = CH_GT;
						end else if (ent_len_q == 3'd4 && ent_buf_q == ENT_QUOT) begin
							oc_valid = 1'b1;
							oc       = CH_QUOT;
						end else if (ent_len_q == 3'd4 && ent_buf_q == ENT_APOS) begin
							oc_valid = 1'b1;
							oc       = CH_APOS;
						end
					end
					clear_markup = 1'b1;
				end else begin
					ent_buf_d = {ent_buf_q[ENT_W-CHAR_BITS-1:0], CHAR_BITS'(c)};
					if (ent_len_q < 3'd4)
						ent_len_d = ent_len_q + 3'd1;
					else
						ent_long_d = 1'b1;
				end
			end
			default: begin
				// plain text; the unused mode code lands here too
				if (c == CH_LT) begin
					clear_markup = 1'b1;
				end else if (c == CH_AMP) begin
					clear_markup = 1'b1;
				end else if (c == CH_NBSP) begin
					oc_valid = 1'b1;
					oc       = CH_SPACE;
				end else if (c == CH_LF) begin
					oc_valid = 1'b0;
				end else if (is_ws) begin
					if (!last_space_q) begin
						oc_valid = 1'b1;
						oc       = CH_SPACE;
					end
				end else begin
					oc_valid = 1'b1;
					oc       = c;
				end
			end
		endcase

		if (clear_markup) begin
			tag_match_d = TM_EMPTY;
			tag_done_d  = 1'b0;
			ent_buf_d   = '0;
			ent_len_d   = 3'd0;
			ent_long_d  = 1'b0;
			if (mode_q == MODE_TAG || mode_q == MODE_ENT)
				mode_d = MODE_PLAIN;
			else if (c == CH_LT)
				mode_d = MODE_TAG;
			else
				mode_d = MODE_ENT;
		end

		emitted_d    = emitted_q || oc_valid;
		last_space_d = oc_valid ? (oc == CH_SPACE) : last_space_q;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid)
			data_s1 <= src_data;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			data_s2.out_char    <= oc_valid ? oc : 8'h00;
			data_s2.out_valid   <= oc_valid;
			data_s2.end_of_text <= data_s1.last;
		end
	end

	// parser state, committed as a transaction moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_PLAIN;
			tag_match_q  <= TM_EMPTY;
			tag_done_q   <= 1'b0;
			ent_buf_q    <= '0;
			ent_len_q    <= 3'd0;
			ent_long_q   <= 1'b0;
			emitted_q    <= 1'b0;
			last_space_q <= 1'b0;
		end else if (advance_s1) begin
			if (data_s1.last) begin
				mode_q       <= MODE_PLAIN;
				tag_match_q  <= TM_EMPTY;
				tag_done_q   <= 1'b0;
				ent_buf_q    <= '0;
				ent_len_q    <= 3'd0;
				ent_long_q   <= 1'b0;
				emitted_q    <= 1'b0;
				last_space_q <= 1'b0;
			end else begin
				mode_q       <= mode_d;
				tag_match_q  <= tag_match_d;
				tag_done_q   <= tag_done_d;
				ent_buf_q    <= ent_buf_d;
				ent_len_q    <= ent_len_d;
				ent_long_q   <= ent_long_d;
				emitted_q    <= emitted_d;
				last_space_q <= last_space_d;
			end
		end
	end

	// parser sits at the start of a fresh text
	assign text_idle = mode_q == MODE_PLAIN && !emitted_q && !last_space_q && ent_len_q == 3'd0;

`include "html_to_text_stripper_assert.svh"

	`H2T_ASSERT_NEXT(a_last_clears, advance_s1 && data_s1.last, text_idle, "state kept past last")
	`H2T_ASSERT_IMPL(a_ent_idle, mode_q != MODE_ENT, ent_len_q == 3'd0 && !ent_long_q, "entity left over")
	`H2T_ASSERT_IMPL(a_space_emitted, last_space_q, emitted_q, "space flag with nothing emitted")
	`H2T_ASSERT_IMPL(a_long_sat, ent_long_q, ent_len_q == 3'd4, "overlong entity, length not saturated")

endmodule

FILE: test/html_to_text_stripper_tb.sv
// Self-checking testbench for html_to_text_stripper: directed and random rich text in,
// plain characters checked against an in-bench model of the stripper.
// Depends on h2t_pkg and the html_to_text_stripper RTL.
module html_to_text_stripper_tb;
	import h2t_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int RANDOM_ITEMS = 1400;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_ready;
	src_t src_data = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res_data;

	html_to_text_stripper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	// Shadow copy of the parser state, advanced once per accepted source transaction.
	logic [1:0]       sh_mode;
	logic [2:0]       sh_tag;
	logic             sh_name_done;
	logic [ENT_W-1:0] sh_ent;
	logic [2:0]       sh_ent_len;
	logic             sh_ent_long;
	logic             sh_emitted;
	logic             sh_space;

	// Plain-text results still owed by the DUT, oldest first.
	res_t plain_due[$];
	int   bad_chars = 0;
	int   chars_sent = 0;
	// Clearing this removes all random idling on both channels.
	bit   gaps_on = 1'b1;

	initial begin
		forever #1 clk = ~clk;
	end

	// Watchdog: generous bound over the slowest legal run.
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	// Mostly short gaps, now and then a long one; none while gaps_on is clear.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	function automatic void forget_markup();
		sh_mode      = MODE_PLAIN;
		sh_tag       = TM_EMPTY;
		sh_name_done = 1'b0;
		sh_ent       = '0;
		sh_ent_len   = '0;
		sh_ent_long  = 1'b0;
	endfunction

	function automatic void restart_text();
		forget_markup();
		sh_emitted = 1'b0;
		sh_space   = 1'b0;
	endfunction

	// Tag name recognizer for br, p and /p; anything else sticks at TM_NONE.
	function automatic logic [2:0] next_tag_match(input logic [2:0] m, input logic [7:0] c);
		case (m)
		TM_EMPTY: begin
			if (c == CH_B)
				return TM_B;
			if (c == CH_P)
				return TM_P;
			if (c == CH_SLASH)
				return TM_SLASH;
			return TM_NONE;
		end
		TM_B: return (c == CH_R) ? TM_BR : TM_NONE;
		TM_SLASH: return (c == CH_P) ? TM_SLASH_P : TM_NONE;
		default: return TM_NONE;
		endcase
	endfunction

	// Expected result of one source character; updates the shadow state.
	function automatic res_t strip_char(input logic [7:0] c, input logic lst);
		res_t       r;
		logic       emit;
		logic [7:0] oc;
		emit = 1'b0;
		oc   = '0;
		case (sh_mode)
		MODE_TAG: begin
			if (c == CH_GT) begin
				if (sh_tag == TM_BR) begin
					emit = 1'b1;
					oc   = CH_LF;
				end else if ((sh_tag == TM_P || sh_tag == TM_SLASH_P) && sh_emitted) begin
					emit = 1'b1;
					oc   = CH_LF;
				end
				forget_markup();
			end else if (!sh_name_done) begin
				// a space ends the name, the rest of the tag is ignored
				if (c == CH_SPACE)
					sh_name_done = 1'b1;
				else
					sh_tag = next_tag_match(sh_tag, c);
			end
		end
		MODE_ENT: begin
			if (c == CH_SEMI) begin
				if (!sh_ent_long) begin
					if (sh_ent_len == 3'd3 && sh_ent == ENT_AMP) begin
						emit = 1'b1;
						oc   = CH_AMP;
					end else if (sh_ent_len == 3'd2 && sh_ent == ENT_LT) begin
						emit = 1'b1;
						oc   = CH_LT;
					end else if (sh_ent_len == 3'd2 && sh_ent == ENT_GT) begin
						emit = 1'b1;
						oc   = CH_GT;
					end else if (sh_ent_len == 3'd4 && sh_ent == ENT_QUOT) begin
						emit = 1'b1;
						oc   = CH_QUOT;
					end else if (sh_ent_len == 3'd4 && sh_ent == ENT_APOS) begin
						emit = 1'b1;
						oc   = CH_APOS;
					end
				end
				forget_markup();
			end else begin
				// keep the last four characters; a fifth marks the entity as unknown
				sh_ent = {sh_ent[ENT_W-CHAR_BITS-1:0], c};
				if (sh_ent_len < 3'd4)
					sh_ent_len = sh_ent_len + 3'd1;
				else
					sh_ent_long = 1'b1;
			end
		end
		default: begin
			// plain text; the unused mode code lands here as well
			if (c == CH_LT) begin
				forget_markup();
				sh_mode = MODE_TAG;
			end else if (c == CH_AMP) begin
				forget_markup();
				sh_mode = MODE_ENT;
			end else if (c == CH_NBSP) begin
				emit = 1'b1;
				oc   = CH_SPACE;
			end else if (c == CH_LF) begin
				emit = 1'b0;
			end else if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE || c == CH_NEL) begin
				// collapsible whitespace
				if (!sh_space) begin
					emit = 1'b1;
					oc   = CH_SPACE;
				end
			end else begin
				emit = 1'b1;
				oc   = c;
			end
		end
		endcase
		if (emit) begin
			sh_emitted = 1'b1;
			sh_space   = (oc == CH_SPACE);
		end
		r.out_char    = emit ? oc : 8'h00;
		r.out_valid   = emit;
		r.end_of_text = lst;
		if (lst)
			restart_text();
		return r;
	endfunction

	// Sampling at the rising edge: predict on every source transaction, check every
	// result transaction against the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (src_valid && src_ready)
				plain_due.push_back(strip_char(src_data.in_char, src_data.last));
			if (res_valid && res_ready) begin
				if (plain_due.size() == 0) begin
					bad_chars++;
					if (bad_chars <= MAX_REPORTS)
						$display("unexpected result: char %02h valid %0b end %0b",
							res_data.out_char, res_data.out_valid, res_data.end_of_text);
				end else begin
					want = plain_due.pop_front();
					if (res_data.out_char !== want.out_char ||
							res_data.out_valid !== want.out_valid ||
							res_data.end_of_text !== want.end_of_text) begin
						bad_chars++;
						if (bad_chars <= MAX_REPORTS)
							$display("mismatch char/valid/end: exp %02h/%0b/%0b got %02h/%0b/%0b",
								want.out_char, want.out_valid, want.end_of_text,
								res_data.out_char, res_data.out_valid, res_data.end_of_text);
					end
				end
			end
		end
	end

	// Result side back-pressure: runs of ready, then random stalls.
	initial begin
		int run_len;
		int stall;
		forever begin
			run_len = $urandom_range(1, 20);
			@(negedge clk);
			res_ready <= 1'b1;
			repeat (run_len - 1) @(negedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				@(negedge clk);
				res_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	// One source transaction: optional idle gap, then hold valid until accepted.
	task automatic send_char(input logic [7:0] c, input logic lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			src_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		src_valid        <= 1'b1;
		src_data.in_char <= c;
		src_data.last    <= lst;
		do
			@(posedge clk);
		while (!src_ready);
		chars_sent++;
	endtask

	// Whole string; last goes on its final character when asked.
	task automatic send_str(input string s, input bit end_text);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], end_text && (i == s.len() - 1));
	endtask

	// Random text: the end of a text may fall anywhere, inside markup too.
	task automatic put_char(input logic [7:0] c);
		send_char(c, $urandom_range(0, 39) == 0);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endtask

	task automatic put_letters(input int n);
		repeat (n) put_char(8'($urandom_range(8'h61, 8'h7A)));
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		src_valid <= 1'b0;
		while (plain_due.size() != 0)
			@(posedge clk);
	endtask

	// Whitespace at the start of text, collapsing, character extremes, no-break
	// space, dropped LF, stray closers in plain text; a leading p tag gives nothing.
	task automatic test_plain_edges();
		send_str("<p>", 1'b0);
		send_char(CH_SPACE, 1'b0);
		send_char(CH_TAB, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(CH_NBSP, 1'b0);
		send_char(CH_NEL, 1'b0);
		send_char(CH_LF, 1'b0);
		send_str(">;", 1'b0);
		send_char(CH_CR, 1'b1);
	endtask

	// Empty tag name, a known entity, p after output, an over-long entity, and a
	// text that ends inside an open tag.
	task automatic test_markup_edges();
		send_str("< br>", 1'b0);
		send_str("&amp;", 1'b0);
		send_str("<p>", 1'b0);
		send_str("&quote;", 1'b0);
		send_str("<br", 1'b1);
	endtask

	// Mix of well-formed tags and entities with random content, plus noise.
	task automatic test_random_text(input int target);
		int kind;
		while (chars_sent < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				put_char(8'($urandom_range(0, 255)));
			end else if (kind < 50) begin
				case ($urandom_range(0, 3))
				0: put_char(CH_SPACE);
				1: put_char(8'($urandom_range(CH_TAB, CH_CR)));
				2: put_char(CH_NEL);
				default: put_char(CH_NBSP);
				endcase
			end else if (kind < 75) begin
				put_char(CH_LT);
				case ($urandom_range(0, 9))
				0: put_str("br");
				1: put_str("p");
				2: put_str("/p");
				3: put_str("b");
				4: put_str("/");
				5: put_str("br/");
				6: put_str("pre");
				7: ;
				default: put_letters($urandom_range(1, 4));
				endcase
				if ($urandom_range(0, 3) == 0) begin
					put_char(CH_SPACE);
					put_letters($urandom_range(0, 5));
				end
				// an occasional tag is left open
				if ($urandom_range(0, 9) != 0)
					put_char(CH_GT);
			end else begin
				put_char(CH_AMP);
				case ($urandom_range(0, 9))
				0: put_str("amp");
				1: put_str("lt");
				2: put_str("gt");
				3: put_str("quot");
				4: put_str("apos");
				5: put_str("quote");
				6: put_str("am");
				7: ;
				default: put_letters($urandom_range(1, 6));
				endcase
				if ($urandom_range(0, 9) != 0)
					put_char(CH_SEMI);
			end
		end
	endtask

	// Full-rate stretch: no idling on either channel.
	task automatic test_back_to_back(input int count);
		gaps_on = 1'b0;
		test_random_text(chars_sent + count);
		gaps_on = 1'b1;
	endtask

	initial begin
		restart_text();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_plain_edges();
		test_markup_edges();
		test_random_text(chars_sent + RANDOM_ITEMS / 2);
		// stop sending until the DUT has returned everything
		hold_until_drained();
		test_back_to_back(250);
		test_random_text(RANDOM_ITEMS + 35);

		@(negedge clk);
		src_valid <= 1'b0;
		while (plain_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (bad_chars == 0 && plain_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/h2t_pkg.sv
rtl/core/html_to_text_stripper.sv
test/html_to_text_stripper_tb.sv
